FILE: rtl/ued_pkg.sv
// shared types and codes for the unhandled encoding dedup table
`default_nettype none

package ued_pkg;

    // fill counter covers the largest table size of 256 slots
    localparam int FILL_W = 9;

    localparam logic [1:0] ST_IGNORED = 2'd0;
    localparam logic [1:0] ST_HIT     = 2'd1;
    localparam logic [1:0] ST_NEW     = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [63:0]       first_pc;
        logic [31:0]       first_enc;
        logic [31:0]       misses;
        logic [31:0]       zero_hits;
        logic [FILL_W-1:0] fill;
    } hart_rec_t;

    typedef struct packed {
        logic [31:0] enc;
        logic [63:0] pc;
        logic [31:0] hits;
    } entry_t;

endpackage

`default_nettype wire

FILE: rtl/ued_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module ued_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/unhandled_encoding_dedup_table.sv
// top level: per-hart dedup table of unhandled instruction traps
// paths: a bad hart is answered straight from idle; a zero encoding or an empty table skips
// the scan; a hit stops at the matching slot; a miss scans every occupied slot, all when full
// one request at a time, taken only in idle; the entry read port walks one slot a cycle
// results come out on done for one cycle; the receiver cannot stall
// reset clears control and per-hart valid bits; slots above a hart's fill count are never compared
`default_nettype none

module unhandled_encoding_dedup_table
    import ued_pkg::*;
#(
    parameter int HARTS         = 4,
    parameter int TABLE_ENTRIES = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [7:0]  hart,
    input  wire logic [31:0] insn_word,
    input  wire logic [63:0] trap_pc,
    output logic             done,
    output logic [1:0]       status,
    output logic [4:0]       slot,
    output logic [31:0]      entry_count,
    output logic             first_taken,
    output logic [31:0]      overflow_count
);

    localparam int HART_W = (HARTS > 1) ? $clog2(HARTS) : 1;
    localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ENT_N  = HARTS * TABLE_ENTRIES;
    localparam int ENT_AW = (ENT_N > 1) ? $clog2(ENT_N) : 1;
    localparam int HREC_W = $bits(hart_rec_t);
    localparam int ENT_W  = $bits(entry_t);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [HART_W-1:0] hart_reg, hart_next;
    logic [31:0]       enc_reg, enc_next;
    logic [63:0]       pc_reg, pc_next;
    logic [ENT_AW-1:0] base_reg, base_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    hart_rec_t         rec_reg, rec_next;
    logic              taken_reg, taken_next;
    logic [HARTS-1:0]  hvalid_reg, hvalid_next;

    logic              done_reg, done_next;
    logic [1:0]        status_reg, status_next;
    logic [4:0]        slot_reg, slot_next;
    logic [31:0]       count_reg, count_next;
    logic              taken_out_reg, taken_out_next;
    logic [31:0]       ovf_reg, ovf_next;

    logic              hart_we;
    hart_rec_t         hart_wdata;
    logic [HREC_W-1:0] hart_rdata;
    logic              ent_we;
    logic [ENT_AW-1:0] ent_waddr;
    entry_t            ent_wdata;
    logic [ENT_AW-1:0] ent_raddr;
    logic [ENT_W-1:0]  ent_rdata;
    entry_t            ent_rd;

    assign ent_rd = entry_t'(ent_rdata);

    ued_ram #(
        .WIDTH (HREC_W),
        .DEPTH (HARTS),
        .ADDR_W(HART_W)
    ) u_hart_ram (
        .clk  (clk),
        .we   (hart_we),
        .waddr(hart_reg),
        .wdata(HREC_W'(hart_wdata)),
        .raddr(hart[HART_W-1:0]),
        .rdata(hart_rdata)
    );

    ued_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENT_N),
        .ADDR_W(ENT_AW)
    ) u_entry_ram (
        .clk  (clk),
        .we   (ent_we),
        .waddr(ent_waddr),
        .wdata(ENT_W'(ent_wdata)),
        .raddr(ent_raddr),
        .rdata(ent_rdata)
    );

    always_comb
    begin
        hart_rec_t         rec;
        logic [31:0]       cnt;
        logic [SLOT_W-1:0] fslot;

        state_next     = state_reg;
        hart_next      = hart_reg;
        enc_next       = enc_reg;
        pc_next        = pc_reg;
        base_next      = base_reg;
        idx_next       = idx_reg;
        rec_next       = rec_reg;
        taken_next     = taken_reg;
        hvalid_next    = hvalid_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        slot_next      = slot_reg;
        count_next     = count_reg;
        taken_out_next = taken_out_reg;
        ovf_next       = ovf_reg;
        hart_we        = 1'b0;
        hart_wdata     = rec_reg;
        ent_we         = 1'b0;
        ent_waddr      = base_reg + ENT_AW'(idx_reg);
        ent_wdata      = '0;
        ent_raddr      = base_reg + ENT_AW'(idx_reg);
        rec            = rec_reg;
        cnt            = '0;
        fslot          = SLOT_W'(rec_reg.fill);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (hart < 8'(HARTS))
                    begin
                        hart_next  = hart[HART_W-1:0];
                        enc_next   = insn_word;
                        pc_next    = trap_pc;
                        base_next  = ENT_AW'(hart[HART_W-1:0]) * ENT_AW'(TABLE_ENTRIES);
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        done_next      = 1'b1;
                        status_next    = ST_IGNORED;
                        slot_next      = '0;
                        count_next     = '0;
                        taken_out_next = 1'b0;
                        ovf_next       = '0;
                    end
                end
            end

            S_LOAD:
            begin
                rec        = hvalid_reg[hart_reg] ? hart_rec_t'(hart_rdata) : '0;
                taken_next = 1'b0;
                // sticky capture stays open while the stored encoding is zero
                if (rec.first_enc == '0)
                begin
                    rec.first_enc = enc_reg;
                    rec.first_pc  = pc_reg;
                    taken_next    = 1'b1;
                end
                rec_next = rec;
                idx_next = '0;
                // occupied slots form a prefix, a zero encoding can only meet the first free one
                if (enc_reg == '0 || rec.fill == '0)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    ent_raddr  = base_reg;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (ent_rd.enc == enc_reg)
                begin
                    cnt            = ent_rd.hits + 32'd1;
                    ent_we         = 1'b1;
                    ent_wdata.enc  = ent_rd.enc;
                    ent_wdata.pc   = ent_rd.pc;
                    ent_wdata.hits = cnt;
                    hart_we        = 1'b1;
                    hvalid_next[hart_reg] = 1'b1;
                    done_next      = 1'b1;
                    status_next    = ST_HIT;
                    slot_next      = 5'(idx_reg);
                    count_next     = cnt;
                    taken_out_next = taken_reg;
                    ovf_next       = rec_reg.misses;
                    state_next     = S_IDLE;
                end
                else if (FILL_W'(idx_reg) + FILL_W'(1) == rec_reg.fill)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    idx_next  = idx_reg + SLOT_W'(1);
                    ent_raddr = base_reg + ENT_AW'(idx_next);
                end
            end

            S_FINISH:
            begin
                rec = rec_reg;
                if (rec_reg.fill < FILL_W'(TABLE_ENTRIES))
                begin
                    if (enc_reg == '0)
                    begin
                        // zero encoding counts in the free slot without claiming it
                        rec.zero_hits = rec_reg.zero_hits + 32'd1;
                        cnt           = rec.zero_hits;
                        status_next   = ST_HIT;
                    end
                    else
                    begin
                        ent_we         = 1'b1;
                        ent_waddr      = base_reg + ENT_AW'(fslot);
                        ent_wdata.enc  = enc_reg;
                        ent_wdata.pc   = pc_reg;
                        ent_wdata.hits = 32'd1;
                        rec.fill       = rec_reg.fill + FILL_W'(1);
                        rec.zero_hits  = '0;
                        cnt            = 32'd1;
                        status_next    = ST_NEW;
                    end
                    slot_next = 5'(fslot);
                end
                else
                begin
                    rec.misses  = rec_reg.misses + 32'd1;
                    status_next = ST_FULL;
                    slot_next   = '0;
                end
                hart_we        = 1'b1;
                hart_wdata     = rec;
                hvalid_next[hart_reg] = 1'b1;
                done_next      = 1'b1;
                count_next     = cnt;
                taken_out_next = taken_reg;
                ovf_next       = rec.misses;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hvalid_reg    <= '0;
            done_reg      <= 1'b0;
            status_reg    <= ST_IGNORED;
            slot_reg      <= '0;
            count_reg     <= '0;
            taken_out_reg <= 1'b0;
            ovf_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            hvalid_reg    <= hvalid_next;
            done_reg      <= done_next;
            status_reg    <= status_next;
            slot_reg      <= slot_next;
            count_reg     <= count_next;
            taken_out_reg <= taken_out_next;
            ovf_reg       <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hart_reg  <= hart_next;
        enc_reg   <= enc_next;
        pc_reg    <= pc_next;
        base_reg  <= base_next;
        idx_reg   <= idx_next;
        rec_reg   <= rec_next;
        taken_reg <= taken_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign slot           = slot_reg;
    assign entry_count    = count_reg;
    assign first_taken    = taken_out_reg;
    assign overflow_count = ovf_reg;

    a_bad_hart: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && hart >= 8'(HARTS)) |=> (done && status == ST_IGNORED))
        else $error("bad hart request did not give an ignored result");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (slot == '0 && entry_count == '0))
        else $error("overflow result carries a slot or count");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hart_we |-> (hart_wdata.fill <= FILL_W'(TABLE_ENTRIES)))
        else $error("fill count above table size");

    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && done_next) |=> !busy)
        else $error("busy held after result");

endmodule

`default_nettype wire
